// ===== hdl/weighted_two_queue_scheduler_defines.svh =====
// assertion macros used by the scheduler control rtl (wtqs_ctrl)
`ifndef WEIGHTED_TWO_QUEUE_SCHEDULER_DEFINES_SVH
`define WEIGHTED_TWO_QUEUE_SCHEDULER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define WTQS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wtqs check failed");

// next-cycle implication, checked out of reset
`define WTQS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wtqs check failed");

`endif

// ===== hdl/wtqs_pkg.sv =====
// shared types and constants of the weighted two-queue scheduler
`default_nettype none

package wtqs_pkg;

  localparam int QueueDepth = 16;
  localparam int PtrW       = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);
  localparam int TurnW      = 4;

  localparam logic CmdEnq  = 1'b0;
  localparam logic CmdNext = 1'b1;

  localparam logic QSelCommon = 1'b0;
  localparam logic QSelPref   = 1'b1;

  localparam logic [1:0] StQueued = 2'd0;
  localparam logic [1:0] StFull   = 2'd1;
  localparam logic [1:0] StServed = 2'd2;
  localparam logic [1:0] StEmpty  = 2'd3;

  localparam logic [TurnW-1:0] TurnsReset = TurnW'(2);

  typedef struct packed {
    logic signed [31:0] id;
    logic [7:0]         age;
    logic               pref;
  } rec_t;

  localparam int RecW = $bits(rec_t);

  typedef struct packed {
    logic            we;
    logic [PtrW-1:0] waddr;
    rec_t            wdata;
    logic            re;
    logic [PtrW-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic       from;
    logic       common_empty;
    logic       pref_empty;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/wtqs_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
`default_nettype none

module wtqs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/wtqs_ctrl.sv =====
// queue pointers, round position and the per-item decision
`default_nettype none

module wtqs_ctrl import wtqs_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic             cmd_i,
  input  wire logic             queue_select_i,
  input  wire rec_t             rec_i,
  input  wire logic             cfg_we_i,
  input  wire logic [TurnW-1:0] cfg_wdata_i,
  output ram_req_t              common_req_o,
  output ram_req_t              pref_req_o,
  output res_t                  res_o
);

  `include "weighted_two_queue_scheduler_defines.svh"

  logic [PtrW-1:0]  common_head_q, common_head_d, pref_head_q, pref_head_d;
  logic [CntW-1:0]  common_cnt_q, common_cnt_d, pref_cnt_q, pref_cnt_d;
  logic [TurnW-1:0] slot_q, slot_d, turns_q, turns_k, slot_cur;
  logic             valid_q, from_q, from_d, use_pref;
  logic [1:0]       status_q, status_d;

  assign turns_k = (turns_q == '0) ? TurnW'(1) : turns_q;

  always_comb begin
    common_head_d = common_head_q;
    pref_head_d   = pref_head_q;
    common_cnt_d  = common_cnt_q;
    pref_cnt_d    = pref_cnt_q;
    slot_d        = slot_q;
    status_d      = status_q;
    from_d        = 1'b0;
    slot_cur      = slot_q;
    use_pref      = 1'b0;
    common_req_o  = '0;
    pref_req_o    = '0;
    common_req_o.wdata = rec_i;
    pref_req_o.wdata   = rec_i;
    common_req_o.waddr = common_head_q + common_cnt_q[PtrW-1:0];
    pref_req_o.waddr   = pref_head_q + pref_cnt_q[PtrW-1:0];
    common_req_o.raddr = common_head_q;
    pref_req_o.raddr   = pref_head_q;
    if (accept_i) begin
      if (cmd_i == CmdEnq) begin
        if (queue_select_i == QSelPref) begin
          if (pref_cnt_q == CntW'(QueueDepth)) begin
            status_d = StFull;
          end else begin
            status_d      = StQueued;
            pref_req_o.we = 1'b1;
            pref_cnt_d    = pref_cnt_q + CntW'(1);
          end
        end else begin
          if (common_cnt_q == CntW'(QueueDepth)) begin
            status_d = StFull;
          end else begin
            status_d        = StQueued;
            common_req_o.we = 1'b1;
            common_cnt_d    = common_cnt_q + CntW'(1);
          end
        end
      end else if (common_cnt_q == '0 && pref_cnt_q == '0) begin
        status_d = StEmpty;
        slot_d   = TurnW'(1);
      end else begin
        // an empty turn queue hands the turn to the other queue
        use_pref = (slot_q == '0);
        if (use_pref && pref_cnt_q == '0) begin
          use_pref = 1'b0;
          slot_cur = TurnW'(1);
        end else if (!use_pref && common_cnt_q == '0) begin
          use_pref = 1'b1;
          slot_cur = '0;
        end
        status_d = StServed;
        from_d   = use_pref;
        if (use_pref) begin
          pref_req_o.re = 1'b1;
          pref_head_d   = pref_head_q + PtrW'(1);
          pref_cnt_d    = pref_cnt_q - CntW'(1);
        end else begin
          common_req_o.re = 1'b1;
          common_head_d   = common_head_q + PtrW'(1);
          common_cnt_d    = common_cnt_q - CntW'(1);
        end
        slot_d = (slot_cur >= turns_k) ? '0 : slot_cur + TurnW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      common_head_q <= '0;
      pref_head_q   <= '0;
      common_cnt_q  <= '0;
      pref_cnt_q    <= '0;
      slot_q        <= TurnW'(1);
      turns_q       <= TurnsReset;
      valid_q       <= 1'b0;
      status_q      <= StQueued;
      from_q        <= 1'b0;
    end else begin
      common_head_q <= common_head_d;
      pref_head_q   <= pref_head_d;
      common_cnt_q  <= common_cnt_d;
      pref_cnt_q    <= pref_cnt_d;
      slot_q        <= slot_d;
      valid_q       <= accept_i;
      status_q      <= status_d;
      from_q        <= from_d;
      if (cfg_we_i) begin
        turns_q <= cfg_wdata_i;
      end
    end
  end

  // counts are already the post-item values while the result is shown
  assign res_o.valid        = valid_q;
  assign res_o.status       = status_q;
  assign res_o.from         = from_q;
  assign res_o.common_empty = (common_cnt_q == '0);
  assign res_o.pref_empty   = (pref_cnt_q == '0);

  `WTQS_ASSERT_IMP(a_common_cnt_range, 1'b1, common_cnt_q <= CntW'(QueueDepth))
  `WTQS_ASSERT_IMP(a_pref_cnt_range, 1'b1, pref_cnt_q <= CntW'(QueueDepth))
  `WTQS_ASSERT_IMP(a_one_access, 1'b1,
                   $countones({common_req_o.we, common_req_o.re, pref_req_o.we, pref_req_o.re}) <= 1)
  `WTQS_ASSERT_NXT(a_both_empty,
                   accept_i && cmd_i == CmdNext && common_cnt_q == '0 && pref_cnt_q == '0,
                   status_q == StEmpty && slot_q == TurnW'(1))
  `WTQS_ASSERT_NXT(a_full_drop,
                   accept_i && cmd_i == CmdEnq && queue_select_i == QSelCommon &&
                   common_cnt_q == CntW'(QueueDepth),
                   status_q == StFull && $stable(common_cnt_q))

endmodule

`default_nettype wire

// ===== hdl/weighted_two_queue_scheduler.sv =====
// top level: two record rams around the scheduling control
// the result strobe rises in the cycle after start is taken
// throughput: one item per cycle; busy stays low, each access is one ram port
// a call-next reads the head entry, the ram's registered read feeds the result
// the result is shown for one cycle only, the receiver cannot stall it
// reset: queues empty, round slot 1, common_turns 2; ram contents are not cleared
`default_nettype none

module weighted_two_queue_scheduler import wtqs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              cmd_i,
  input  wire logic              queue_select_i,
  input  wire logic signed [31:0] patient_id_i,
  input  wire logic        [7:0] age_i,
  input  wire logic              preferential_i,
  input  wire logic              cfg_we_i,
  input  wire logic [TurnW-1:0]  cfg_wdata_i,
  output logic                   strobe_o,
  output logic             [1:0] status_o,
  output logic                   served_from_o,
  output logic signed     [31:0] out_id_o,
  output logic             [7:0] out_age_o,
  output logic                   out_preferential_o,
  output logic                   common_empty_o,
  output logic                   pref_empty_o
);

  ram_req_t        common_req, pref_req;
  res_t            res;
  rec_t            in_rec, rd_rec;
  logic [RecW-1:0] common_rdata, pref_rdata;
  logic            accept, served;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign in_rec.id   = patient_id_i;
  assign in_rec.age  = age_i;
  assign in_rec.pref = preferential_i;

  wtqs_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .cmd_i          (cmd_i),
    .queue_select_i (queue_select_i),
    .rec_i          (in_rec),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .common_req_o   (common_req),
    .pref_req_o     (pref_req),
    .res_o          (res)
  );

  wtqs_ram #(.Width(RecW), .Depth(QueueDepth)) u_common_ram (
    .clk_i   (clk_i),
    .we_i    (common_req.we),
    .waddr_i (common_req.waddr),
    .wdata_i (common_req.wdata),
    .re_i    (common_req.re),
    .raddr_i (common_req.raddr),
    .rdata_o (common_rdata)
  );

  wtqs_ram #(.Width(RecW), .Depth(QueueDepth)) u_pref_ram (
    .clk_i   (clk_i),
    .we_i    (pref_req.we),
    .waddr_i (pref_req.waddr),
    .wdata_i (pref_req.wdata),
    .re_i    (pref_req.re),
    .raddr_i (pref_req.raddr),
    .rdata_o (pref_rdata)
  );

  assign rd_rec = res.from ? rec_t'(pref_rdata) : rec_t'(common_rdata);
  assign served = (res.status == StServed);

  assign strobe_o           = res.valid;
  assign status_o           = res.status;
  assign served_from_o      = served ? res.from : 1'b0;
  assign out_id_o           = served ? rd_rec.id : '0;
  assign out_age_o          = served ? rd_rec.age : '0;
  assign out_preferential_o = served ? rd_rec.pref : 1'b0;
  assign common_empty_o     = res.common_empty;
  assign pref_empty_o       = res.pref_empty;

endmodule

`default_nettype wire
